FILE: sv/sbc_ba_pkg.sv
// sbc bit allocation package: payload types, configuration codes and offset table
// no dependencies; imported by every module of the block
package sbc_ba_pkg;

	localparam int MAX_SUBBANDS = 8;
	localparam int MAX_CHANNELS = 2;
	localparam int STORE_DEPTH  = MAX_SUBBANDS * MAX_CHANNELS;

	localparam logic [4:0]        BITS_CAP     = 5'd16;
	localparam logic signed [5:0] ZERO_SF_NEED = -6'sd5;
	localparam logic signed [6:0] SLICE_FLOOR  = -7'sd21;

	// configuration register indexes
	localparam logic [2:0] CFG_CHANNEL_MODE   = 3'd0;
	localparam logic [2:0] CFG_SNR_RULE       = 3'd1;
	localparam logic [2:0] CFG_EIGHT_SUBBANDS = 3'd2;
	localparam logic [2:0] CFG_RATE_INDEX     = 3'd3;
	localparam logic [2:0] CFG_BITPOOL        = 3'd4;

	// channel mode codes
	localparam logic [1:0] CHMODE_MONO = 2'd0;
	localparam logic [1:0] CHMODE_DUAL = 2'd1;

	typedef struct packed {
		logic       in_channel;
		logic [2:0] in_subband;
		logic [3:0] scale_factor;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic       out_channel;
		logic [2:0] out_subband;
		logic [4:0] alloc_bits;
		logic       out_last;
	} out_item_t;

	typedef struct packed {
		logic [1:0] channel_mode;
		logic       snr_rule;
		logic       eight_subbands;
		logic [1:0] rate_index;
		logic [7:0] bitpool;
	} cfg_t;

	typedef struct packed {
		logic [STORE_DEPTH-1:0][3:0] scales;
		cfg_t                        cfg;
	} job_t;

	// front to back job handshake
	typedef struct packed {
		logic valid;
		job_t job;
	} job_hs_t;

	// loudness offset per sample rate and subband
	function automatic logic signed [3:0] loud_offset(input logic [1:0] rate,
		input logic eight, input logic [2:0] sb);
		logic signed [3:0] o;
		o = 4'sd0;
		if (eight) begin
			if (sb == 3'd0) begin
				case (rate)
					2'd0:    o = -4'sd2;
					2'd1:    o = -4'sd3;
					default: o = -4'sd4;
				endcase
			end else if (sb == 3'd6) begin
				o = (rate == 2'd0) ? 4'sd0 : 4'sd1;
			end else if (sb == 3'd7) begin
				o = (rate == 2'd0) ? 4'sd1 : 4'sd2;
			end
		end else begin
			if (sb[1:0] == 2'd0) begin
				o = (rate == 2'd0) ? -4'sd1 : -4'sd2;
			end else if (sb[1:0] == 2'd3) begin
				o = (rate == 2'd0) ? 4'sd0 : 4'sd1;
			end
		end
		return o;
	endfunction

endpackage

FILE: sv/sbc_bit_allocation_core.sv
// sbc bit allocation top level: front and back joined by the job queue
// depends on sbc_ba_pkg, sbc_ba_front, sbc_ba_back
//
// Scale factors enter one beat each, tagged with channel and subband; a beat with
// in_last set closes the frame, and a snapshot of all sixteen scale factors plus the
// configuration drops into a two-deep job queue, so the next frame can load while the
// back end works. The back end is a single sequencer that walks the group's entries
// one per cycle: one walk for bit need, one walk per slice step of the bitpool
// search, one walk to set allocations and up to two walks of leftover passes, then
// one result beat per channel and subband, after which the job is retired. There
// are 4, 8 or 16 entries per group and at most 37 slice steps; dual channel runs two
// groups. Ordinary input beats are accepted at once, and input stalls only while two
// closed frames wait in the queue.
// Configuration writes are always accepted and apply to the next frame closed.
module sbc_bit_allocation_core import sbc_ba_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_item,
	output logic       out_valid,
	input  logic       out_stall,
	output out_item_t  out_item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data
);

	// job snapshot travelling from front to back
	job_hs_t job_hs;
	logic    job_pop;

	sbc_ba_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.job_hs    (job_hs),
		.job_pop   (job_pop)
	);

	sbc_ba_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_hs    (job_hs),
		.job_pop   (job_pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item)
	);

endmodule

FILE: sv/sbc_ba_front.sv
// sbc bit allocation front: configuration registers, scale factor capture, job queue
// depends on sbc_ba_pkg
module sbc_ba_front import sbc_ba_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  in_item_t   in_item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [7:0] cfg_data,
	output job_hs_t    job_hs,
	input  logic       job_pop
);

	cfg_t       cfg_q;
	logic [STORE_DEPTH-1:0][3:0] scale_q;
	logic [STORE_DEPTH-1:0][3:0] scale_next;
	job_t       fifo_q [2];
	logic       wr_q, rd_q;
	logic [1:0] cnt_q;
	logic       accept, push;

	assign cfg_ready = 1'b1;
	assign in_stall  = (cnt_q == 2'd2);
	assign accept    = in_valid && !in_stall;
	assign push      = accept && in_item.in_last;

	always_comb begin
		scale_next = scale_q;
		scale_next[{in_item.in_channel, in_item.in_subband}] = in_item.scale_factor;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.channel_mode   <= 2'd2;
			cfg_q.snr_rule       <= 1'b0;
			cfg_q.eight_subbands <= 1'b1;
			cfg_q.rate_index     <= 2'd2;
			cfg_q.bitpool        <= 8'd32;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_CHANNEL_MODE:   cfg_q.channel_mode   <= cfg_data[1:0];
				CFG_SNR_RULE:       cfg_q.snr_rule       <= cfg_data[0];
				CFG_EIGHT_SUBBANDS: cfg_q.eight_subbands <= cfg_data[0];
				CFG_RATE_INDEX:     cfg_q.rate_index     <= cfg_data[1:0];
				CFG_BITPOOL:        cfg_q.bitpool        <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			scale_q <= scale_next;
		end
		if (push) begin
			fifo_q[wr_q] <= '{scales: scale_next, cfg: cfg_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= !wr_q;
			end
			if (job_pop) begin
				rd_q <= !rd_q;
			end
			if (push && !job_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!push && job_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	assign job_hs.valid = (cnt_q != 2'd0);
	assign job_hs.job   = fifo_q[rd_q];

endmodule

FILE: sv/sbc_ba_back.sv
// sbc bit allocation back: sequencer for need, slice search, allocation, leftover passes, output
// depends on sbc_ba_pkg
module sbc_ba_back import sbc_ba_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  job_hs_t   job_hs,
	output logic      job_pop,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	typedef enum logic [5:0] {
		ST_IDLE  = 6'b000001,
		ST_NEED  = 6'b000010,
		ST_SLICE = 6'b000100,
		ST_BITS  = 6'b001000,
		ST_PASS  = 6'b010000,
		ST_OUT   = 6'b100000
	} state_t;

	state_t            state_q;
	logic              group_q, pass_q;
	logic [3:0]        j_q;
	logic [4:0]        k_q;
	logic signed [5:0] max_q;
	logic signed [6:0] slice_q;
	logic [5:0]        acc_q;
	logic [9:0]        bc_q;
	logic signed [5:0] need_q [STORE_DEPTH];
	logic [4:0]        bits_q [STORE_DEPTH];
	logic              out_valid_q;
	out_item_t         out_q;

	cfg_t              cfg;
	logic              two_ch, dual, nc2, nb8, j_last;
	logic [4:0]        n_grp, total;
	logic [2:0]        sb;
	logic [3:0]        ent, ocell;
	logic [3:0]        sf;
	logic signed [5:0] loud, need_c, max_nxt, need_rd;
	logic signed [7:0] n8, s8, diff8;
	logic [1:0]        contrib;
	logic [5:0]        sc_fin;
	logic [9:0]        bitsum, pool;
	logic [4:0]        bits_new, bits_rd;
	logic              ochan;
	logic [2:0]        osb;
	logic              can_load, load_out;

	assign cfg    = job_hs.job.cfg;
	assign two_ch = (cfg.channel_mode != CHMODE_MONO);
	assign dual   = (cfg.channel_mode == CHMODE_DUAL);
	assign nc2    = two_ch && !dual;
	assign nb8    = cfg.eight_subbands;
	assign n_grp  = nc2 ? (nb8 ? 5'd16 : 5'd8) : (nb8 ? 5'd8 : 5'd4);
	assign total  = two_ch ? (nb8 ? 5'd16 : 5'd8) : (nb8 ? 5'd8 : 5'd4);
	assign j_last = ({1'b0, j_q} == n_grp - 5'd1);
	assign pool   = {2'b00, cfg.bitpool};

	// stereo groups walk channels interleaved per subband
	always_comb begin
		if (nc2) begin
			sb  = j_q[3:1];
			ent = {j_q[0], j_q[3:1]};
		end else begin
			sb  = j_q[2:0];
			ent = {group_q, j_q[2:0]};
		end
	end

	assign sf   = job_hs.job.scales[ent];
	assign loud = $signed({2'b00, sf}) - 6'(loud_offset(cfg.rate_index, nb8, sb));

	always_comb begin
		if (cfg.snr_rule) begin
			need_c = $signed({2'b00, sf});
		end else if (sf == 4'd0) begin
			need_c = ZERO_SF_NEED;
		end else if (loud > 6'sd0) begin
			need_c = loud >>> 1;
		end else begin
			need_c = loud;
		end
	end

	assign max_nxt = (need_c > max_q) ? need_c : max_q;
	assign need_rd = need_q[ent];
	assign bits_rd = bits_q[ent];
	assign n8      = 8'(need_rd);
	assign s8      = 8'(slice_q);
	assign diff8   = n8 - s8;

	always_comb begin
		if (n8 > s8 + 8'sd1 && n8 < s8 + 8'sd16) begin
			contrib = 2'd1;
		end else if (n8 == s8 + 8'sd1) begin
			contrib = 2'd2;
		end else begin
			contrib = 2'd0;
		end
	end

	assign sc_fin = acc_q + {4'd0, contrib};
	assign bitsum = bc_q + {4'd0, sc_fin};

	always_comb begin
		if (n8 >= s8 + 8'sd2) begin
			bits_new = (diff8 > 8'sd16) ? BITS_CAP : diff8[4:0];
		end else begin
			bits_new = 5'd0;
		end
	end

	// output walk is channel-major
	assign ochan    = nb8 ? k_q[3] : k_q[2];
	assign osb      = nb8 ? k_q[2:0] : {1'b0, k_q[1:0]};
	assign ocell    = {ochan, osb};
	assign can_load = !out_valid_q || !out_stall;
	assign load_out = (state_q == ST_OUT) && can_load && (k_q != total);
	assign job_pop  = (state_q == ST_OUT) && can_load && (k_q == total);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			group_q     <= 1'b0;
			pass_q      <= 1'b0;
			j_q         <= 4'd0;
			k_q         <= 5'd0;
			max_q       <= 6'sd0;
			slice_q     <= 7'sd0;
			acc_q       <= 6'd0;
			bc_q        <= 10'd0;
			out_valid_q <= 1'b0;
		end else begin
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (job_hs.valid) begin
						group_q <= 1'b0;
						j_q     <= 4'd0;
						max_q   <= 6'sd0;
						state_q <= ST_NEED;
					end
				end
				ST_NEED: begin
					max_q <= max_nxt;
					if (j_last) begin
						slice_q <= 7'(max_nxt);
						acc_q   <= 6'd0;
						bc_q    <= 10'd0;
						j_q     <= 4'd0;
						state_q <= ST_SLICE;
					end else begin
						j_q <= j_q + 4'd1;
					end
				end
				ST_SLICE: begin
					acc_q <= sc_fin;
					if (j_last) begin
						j_q <= 4'd0;
						if (bitsum < pool && slice_q > SLICE_FLOOR) begin
							bc_q    <= bitsum;
							slice_q <= slice_q - 7'sd1;
							acc_q   <= 6'd0;
						end else begin
							if (bitsum == pool) begin
								bc_q    <= bitsum;
								slice_q <= slice_q - 7'sd1;
							end
							state_q <= ST_BITS;
						end
					end else begin
						j_q <= j_q + 4'd1;
					end
				end
				ST_BITS: begin
					if (j_last) begin
						j_q     <= 4'd0;
						pass_q  <= 1'b0;
						state_q <= ST_PASS;
					end else begin
						j_q <= j_q + 4'd1;
					end
				end
				ST_PASS: begin
					if (bc_q < pool) begin
						if (!pass_q) begin
							if (bits_rd >= 5'd2 && bits_rd < BITS_CAP) begin
								bc_q <= bc_q + 10'd1;
							end else if (n8 == s8 + 8'sd1 && pool > bc_q + 10'd1) begin
								bc_q <= bc_q + 10'd2;
							end
						end else if (bits_rd < BITS_CAP) begin
							bc_q <= bc_q + 10'd1;
						end
					end
					if (bc_q >= pool || j_last) begin
						j_q <= 4'd0;
						if (!pass_q) begin
							pass_q <= 1'b1;
						end else if (dual && !group_q) begin
							group_q <= 1'b1;
							max_q   <= 6'sd0;
							state_q <= ST_NEED;
						end else begin
							k_q     <= 5'd0;
							state_q <= ST_OUT;
						end
					end else begin
						j_q <= j_q + 4'd1;
					end
				end
				ST_OUT: begin
					if (can_load) begin
						if (k_q != total) begin
							k_q <= k_q + 5'd1;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload stores, no reset
	always_ff @(posedge clk) begin
		if (state_q == ST_NEED) begin
			need_q[ent] <= need_c;
		end
		if (state_q == ST_BITS) begin
			bits_q[ent] <= bits_new;
		end
		if (state_q == ST_PASS && bc_q < pool) begin
			if (!pass_q) begin
				if (bits_rd >= 5'd2 && bits_rd < BITS_CAP) begin
					bits_q[ent] <= bits_rd + 5'd1;
				end else if (n8 == s8 + 8'sd1 && pool > bc_q + 10'd1) begin
					bits_q[ent] <= 5'd2;
				end
			end else if (bits_rd < BITS_CAP) begin
				bits_q[ent] <= bits_rd + 5'd1;
			end
		end
		if (load_out) begin
			out_q.out_channel <= ochan;
			out_q.out_subband <= osb;
			out_q.alloc_bits  <= bits_q[ocell];
			out_q.out_last    <= (k_q == total - 5'd1);
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

FILE: sv/sbc_ba_checker.sv
// sbc bit allocation port checker and its bind to the top level
// depends on sbc_ba_pkg and sbc_bit_allocation_core
module sbc_ba_checker import sbc_ba_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      out_valid,
	input logic      out_stall,
	input out_item_t out_item
);

	// allocation never exceeds the cap
	a_cap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_item.alloc_bits <= BITS_CAP)
		else $error("alloc_bits above cap");

	// frame ends on the top subband of a four or eight subband frame
	a_last_sb: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_item.out_last) |->
		(out_item.out_subband == 3'd3 || out_item.out_subband == 3'd7))
		else $error("last beat on wrong subband");

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(out_item)))
		else $error("stalled beat changed");

endmodule

bind sbc_bit_allocation_core sbc_ba_checker u_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_item  (out_item)
);
